// File: hw/rtl/bayb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bayb_pkg
// Types, widths and helpers shared by the bulge arc vertical bounds pipeline.
// ----------------------------------------------------------------------------
package bayb_pkg;

  localparam int COORD_W = 32;               // Q16.16 coordinates
  localparam int BULGE_W = 24;               // Q7.16 bulge
  localparam int FRAC_W  = 63 - COORD_W;     // fraction bits kept on the chord length
  localparam int AT_W    = BULGE_W;          // bulge magnitude
  localparam int T2_W    = 2 * BULGE_W - 1;  // bulge squared, 1 +- t^2 terms
  localparam int DX_W    = COORD_W + 1;      // differences, sums and their magnitudes
  localparam int SQ_W    = 2 * DX_W;
  localparam int RAD_W   = 128;              // radicand of the chord length
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int MA_W    = ROOT_W;           // multiplier operand a
  localparam int HA_W    = MA_W / 2;
  localparam int HB_W    = 24;
  localparam int MB_W    = 2 * HB_W;         // multiplier operand b
  localparam int PP_W    = HA_W + HB_W;
  localparam int HALF_W  = PP_W + HB_W;
  localparam int PROD_W  = HALF_W + HA_W;
  localparam int WW      = PROD_W + 4;       // signed sums of products
  localparam int SHIFT   = 18 + FRAC_W;      // scaling ahead of the divide
  localparam int DV_W    = WW - SHIFT;
  localparam int Q_W     = COORD_W + 1;      // quotient bits before saturation
  localparam int TOP_W   = DV_W - Q_W;
  localparam int N_PROD  = 5;

  localparam logic [T2_W-1:0] UNIT = T2_W'(64'h1_0000_0000);
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [BULGE_W-1:0] bulge;
  } seg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] low_y;
    logic signed [COORD_W-1:0] high_y;
    logic                      top_reached;
    logic                      bottom_reached;
  } bnd_t;

  // per-item values carried alongside the chord length root
  typedef struct packed {
    logic                      bz;
    logic                      sneg;
    logic                      uneg;
    logic                      dx_neg;
    logic                      sum_neg;
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
    logic [AT_W-1:0]           at;
    logic [DX_W-1:0]           adx;
    logic [DX_W-1:0]           smag;
    logic [T2_W-1:0]           um;
    logic [T2_W-1:0]           k;
  } side_t;

  // per-item values carried alongside the two divide lanes
  typedef struct packed {
    logic                      topf;
    logic                      botf;
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
    logic [1:0]                neg;
    logic [1:0]                sat;
  } div_side_t;

  function automatic logic signed [WW-1:0] apply_sign(input logic [WW-1:0] m,
                                                      input logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bayb_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bayb_isqrt
// Pipelined integer square root, one result bit per stage, floor result and
// an exact flag; side values travel with each transaction.
// ----------------------------------------------------------------------------
module bayb_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [bayb_pkg::RAD_W-1:0]    radicand,
  input  bayb_pkg::side_t               in_side,
  output logic                          out_valid,
  output logic [bayb_pkg::ROOT_W-1:0]   root,
  output logic                          exact,
  output bayb_pkg::side_t               out_side
);
  import bayb_pkg::*;

  logic              vld [1:ROOT_W];
  logic [RAD_W-1:0]  rad [1:ROOT_W];
  logic [ROOT_W-1:0] rt  [1:ROOT_W];
  logic [REM_W-1:0]  rm  [1:ROOT_W];
  side_t             sd  [1:ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_step
    logic              s_v;
    logic [RAD_W-1:0]  s_rad;
    logic [ROOT_W-1:0] s_rt;
    logic [REM_W-1:0]  s_rm;
    side_t             s_sd;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  diff;
    logic              take;

    if (g == 0) begin : g_first
      assign s_v   = in_valid;
      assign s_rad = radicand;
      assign s_rt  = '0;
      assign s_rm  = '0;
      assign s_sd  = in_side;
    end else begin : g_next
      assign s_v   = vld[g];
      assign s_rad = rad[g];
      assign s_rt  = rt[g];
      assign s_rm  = rm[g];
      assign s_sd  = sd[g];
    end

    // bring down the next two radicand bits, try root*4+1
    always_comb begin
      cur   = {s_rm[REM_W-3:0], s_rad[RAD_W-1 -: 2]};
      trial = {1'b0, s_rt, 2'b01};
      take  = (cur >= trial);
      diff  = cur - trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= s_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[g+1] <= s_rad << 2;
        rt[g+1]  <= {s_rt[ROOT_W-2:0], take};
        rm[g+1]  <= take ? diff : cur;
        sd[g+1]  <= s_sd;
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = rt[ROOT_W];
  assign exact     = (rm[ROOT_W] == '0);
  assign out_side  = sd[ROOT_W];

endmodule
`default_nettype wire

// File: hw/rtl/bayb_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bayb_div
// Two-lane pipelined restoring divider by the bulge magnitude, one quotient
// bit per stage, with a remainder-nonzero flag per lane.
// ----------------------------------------------------------------------------
module bayb_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [1:0][bayb_pkg::Q_W-1:0]     dividend,
  input  logic [1:0][bayb_pkg::AT_W-1:0]    rem_init,
  input  logic [bayb_pkg::AT_W-1:0]         divisor,
  input  bayb_pkg::div_side_t               in_side,
  output logic                              out_valid,
  output logic [1:0][bayb_pkg::Q_W-1:0]     quot,
  output logic [1:0]                        rem_nz,
  output bayb_pkg::div_side_t               out_side
);
  import bayb_pkg::*;

  logic                      vld [1:Q_W];
  logic [1:0][Q_W-1:0]       dq  [1:Q_W];
  logic [1:0][AT_W-1:0]      rm  [1:Q_W];
  logic [AT_W-1:0]           dv  [1:Q_W];
  div_side_t                 sd  [1:Q_W];

  for (genvar g = 0; g < Q_W; g++) begin : g_step
    logic                 s_v;
    logic [1:0][Q_W-1:0]  s_dq;
    logic [1:0][AT_W-1:0] s_rm;
    logic [AT_W-1:0]      s_dv;
    div_side_t            s_sd;
    logic [1:0][AT_W:0]   cur;
    logic [1:0][AT_W-1:0] nrem;
    logic [1:0]           take;

    if (g == 0) begin : g_first
      assign s_v  = in_valid;
      assign s_dq = dividend;
      assign s_rm = rem_init;
      assign s_dv = divisor;
      assign s_sd = in_side;
    end else begin : g_next
      assign s_v  = vld[g];
      assign s_dq = dq[g];
      assign s_rm = rm[g];
      assign s_dv = dv[g];
      assign s_sd = sd[g];
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        cur[l]  = {s_rm[l], s_dq[l][Q_W-1]};
        take[l] = (cur[l] >= {1'b0, s_dv});
        nrem[l] = take[l] ? AT_W'(cur[l] - {1'b0, s_dv}) : AT_W'(cur[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= s_v;
      end
    end

    // quotient bits shift in as the dividend bits shift out
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          dq[g+1][l] <= {s_dq[l][Q_W-2:0], take[l]};
          rm[g+1][l] <= nrem[l];
        end
        dv[g+1] <= s_dv;
        sd[g+1] <= s_sd;
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quot      = dq[Q_W];
  assign rem_nz    = {(rm[Q_W][1] != '0), (rm[Q_W][0] != '0)};
  assign out_side  = sd[Q_W];

endmodule
`default_nettype wire

// File: hw/rtl/bulge_arc_y_bounds.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bulge_arc_y_bounds
// Vertical extent of one polyline edge (straight or bulged arc), fully
// pipelined: chord length root, product tree, extreme tests, floor divide.
// ----------------------------------------------------------------------------
//   port    | dir | handshake              | payload
//   --------+-----+------------------------+---------------------------------
//   seg     | in  | seg_valid / seg_stall  | start/end point, bulge (seg_t)
//   bnd     | out | bnd_valid / bnd_stall  | low/high y, extreme flags (bnd_t)
//
// one edge enters per clock while seg_stall is low; each edge passes through
// the 64-stage square root and the 33-stage divider.
// rst clears every stage valid and the valid flags of the output and skid registers.
// a stalled output keeps its result; the next one lands in the skid register,
// and the whole pipeline holds while the skid register is full.
// ----------------------------------------------------------------------------
module bulge_arc_y_bounds (
  input  logic            clk,
  input  logic            rst,
  input  logic            seg_valid,
  output logic            seg_stall,
  input  bayb_pkg::seg_t  seg,
  output logic            bnd_valid,
  input  logic            bnd_stall,
  output bayb_pkg::bnd_t  bnd
);
  import bayb_pkg::*;

  logic en;
  logic skid_v;
  bnd_t skid_d;

  assign en        = !skid_v;
  assign seg_stall = skid_v;

  // stage 1: differences, sum, endpoint order
  logic                      v1;
  logic signed [DX_W-1:0]    dx1, dy1, sum1;
  logic signed [BULGE_W-1:0] bu1;
  logic signed [COORD_W-1:0] lo1, hi1;

  always_ff @(posedge clk) begin
    if (en) begin
      dx1  <= DX_W'(seg.end_x) - DX_W'(seg.start_x);
      dy1  <= DX_W'(seg.end_y) - DX_W'(seg.start_y);
      sum1 <= DX_W'(seg.start_y) + DX_W'(seg.end_y);
      bu1  <= seg.bulge;
      lo1  <= (seg.start_y < seg.end_y) ? seg.start_y : seg.end_y;
      hi1  <= (seg.start_y < seg.end_y) ? seg.end_y : seg.start_y;
    end
  end

  // stage 2: magnitudes
  logic                      v2, bz2, sneg2, dxn2, sumn2;
  logic [DX_W-1:0]           adx2, ady2, smag2;
  logic [AT_W-1:0]           at2;
  logic signed [COORD_W-1:0] lo2, hi2;

  always_ff @(posedge clk) begin
    if (en) begin
      adx2  <= dx1[DX_W-1] ? DX_W'(-dx1) : DX_W'(dx1);
      ady2  <= dy1[DX_W-1] ? DX_W'(-dy1) : DX_W'(dy1);
      smag2 <= sum1[DX_W-1] ? DX_W'(-sum1) : DX_W'(sum1);
      at2   <= bu1[BULGE_W-1] ? AT_W'(-bu1) : AT_W'(bu1);
      bz2   <= (bu1 == '0);
      sneg2 <= bu1[BULGE_W-1];
      dxn2  <= dx1[DX_W-1];
      sumn2 <= sum1[DX_W-1];
      lo2   <= lo1;
      hi2   <= hi1;
    end
  end

  // stage 3: squares
  logic                      v3, bz3, sneg3, dxn3, sumn3;
  logic [SQ_W-1:0]           sqx3, sqy3;
  logic [T2_W-1:0]           t23;
  logic [DX_W-1:0]           adx3, smag3;
  logic [AT_W-1:0]           at3;
  logic signed [COORD_W-1:0] lo3, hi3;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx3  <= adx2 * adx2;
      sqy3  <= ady2 * ady2;
      t23   <= T2_W'(at2 * at2);
      adx3  <= adx2;
      smag3 <= smag2;
      at3   <= at2;
      bz3   <= bz2;
      sneg3 <= sneg2;
      dxn3  <= dxn2;
      sumn3 <= sumn2;
      lo3   <= lo2;
      hi3   <= hi2;
    end
  end

  // stage 4: radicand, 1 - t^2 and 1 + t^2
  logic             v4;
  logic [RAD_W-1:0] rad4;
  side_t            side4;
  logic             uneg_c;

  assign uneg_c = (t23 > UNIT);

  always_ff @(posedge clk) begin
    if (en) begin
      rad4          <= RAD_W'({1'b0, sqx3} + {1'b0, sqy3}) << (2 * FRAC_W);
      side4.bz      <= bz3;
      side4.sneg    <= sneg3;
      side4.uneg    <= uneg_c;
      side4.dx_neg  <= dxn3;
      side4.sum_neg <= sumn3;
      side4.lo      <= lo3;
      side4.hi      <= hi3;
      side4.at      <= at3;
      side4.adx     <= adx3;
      side4.smag    <= smag3;
      side4.um      <= uneg_c ? (t23 - UNIT) : (UNIT - t23);
      side4.k       <= UNIT + t23;
    end
  end

  // chord length
  logic              sq_v, sq_exact;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  bayb_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .radicand  (rad4),
    .in_side   (side4),
    .out_valid (sq_v),
    .root      (sq_root),
    .exact     (sq_exact),
    .out_side  (sq_side)
  );

  // m0: root rounded up for the extreme tests when 1 - t^2 is negative
  logic              vm0;
  logic [ROOT_W-1:0] lf_m0, lsel_m0;
  side_t             side_m0;

  always_ff @(posedge clk) begin
    if (en) begin
      lf_m0   <= sq_root;
      lsel_m0 <= sq_root + ROOT_W'(sq_side.uneg & !sq_exact);
      side_m0 <= sq_side;
    end
  end

  // m1..m3: five products as four partial products each
  logic [MA_W-1:0]   ma [N_PROD];
  logic [MB_W-1:0]   mb [N_PROD];
  logic              vm1, vm2, vm3;
  logic [PP_W-1:0]   pp   [N_PROD][4];
  logic [HALF_W-1:0] half [N_PROD][2];
  logic [PROD_W-1:0] prod [N_PROD];
  side_t             side_m1, side_m2, side_m3;

  always_comb begin
    ma[0] = lsel_m0;                mb[0] = MB_W'(side_m0.um);    // u * L
    ma[1] = MA_W'(side_m0.adx);     mb[1] = MB_W'(side_m0.k);     // dx * k
    ma[2] = MA_W'(side_m0.smag);    mb[2] = MB_W'(side_m0.at);    // sum * t
    ma[3] = MA_W'(side_m0.adx);     mb[3] = MB_W'(side_m0.um);    // dx * u
    ma[4] = lf_m0;                  mb[4] = MB_W'(side_m0.k);     // L * k
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < N_PROD; p++) begin
        pp[p][0] <= ma[p][HA_W-1:0] * mb[p][HB_W-1:0];
        pp[p][1] <= ma[p][HA_W-1:0] * mb[p][MB_W-1:HB_W];
        pp[p][2] <= ma[p][MA_W-1:HA_W] * mb[p][HB_W-1:0];
        pp[p][3] <= ma[p][MA_W-1:HA_W] * mb[p][MB_W-1:HB_W];
        half[p][0] <= HALF_W'(pp[p][0]) + (HALF_W'(pp[p][1]) << HB_W);
        half[p][1] <= HALF_W'(pp[p][2]) + (HALF_W'(pp[p][3]) << HB_W);
        prod[p]    <= PROD_W'(half[p][0]) + (PROD_W'(half[p][1]) << HA_W);
      end
      side_m1 <= side_m0;
      side_m2 <= side_m1;
      side_m3 <= side_m2;
    end
  end

  // c1: signed terms
  logic                 vc1, dneg;
  logic signed [WW-1:0] ul1, dk1, ma1, mb1, lk1;
  side_t                side_c1;

  assign dneg = side_m3.dx_neg ^ side_m3.sneg;

  always_ff @(posedge clk) begin
    if (en) begin
      ul1     <= apply_sign(WW'(prod[0]), side_m3.uneg);
      dk1     <= apply_sign(WW'(prod[1]) << FRAC_W, dneg);
      ma1     <= apply_sign(WW'(prod[2]) << (17 + FRAC_W), side_m3.sum_neg);
      mb1     <= apply_sign(WW'(prod[3]) << FRAC_W, dneg ^ side_m3.uneg);
      lk1     <= $signed(WW'(prod[4]));
      side_c1 <= side_m3;
    end
  end

  // c2: test sums and centre term
  logic                 vc2;
  logic signed [WW-1:0] ts2, bs2, mid2, lk2;
  side_t                side_c2;

  always_ff @(posedge clk) begin
    if (en) begin
      ts2     <= ul1 + dk1;
      bs2     <= ul1 - dk1;
      mid2    <= ma1 + mb1;
      lk2     <= lk1;
      side_c2 <= side_c1;
    end
  end

  // c3: extreme flags and the two numerators
  logic                 vc3, topf3, botf3;
  logic signed [WW-1:0] nt3, nb3;
  side_t                side_c3;

  always_ff @(posedge clk) begin
    if (en) begin
      topf3   <= ts2[WW-1] || (ts2 == '0);
      botf3   <= bs2[WW-1] || (bs2 == '0);
      nt3     <= mid2 + lk2;
      nb3     <= mid2 - lk2;
      side_c3 <= side_c2;
    end
  end

  // c4: scale down, sign and magnitude
  logic                 vc4, topf4, botf4;
  logic signed [WW-1:0] sht, shb;
  logic [1:0][DV_W-1:0] dmag4;
  logic [1:0]           neg4;
  side_t                side_c4;

  assign sht = nt3 >>> SHIFT;
  assign shb = nb3 >>> SHIFT;

  always_ff @(posedge clk) begin
    if (en) begin
      dmag4[0] <= nt3[WW-1] ? DV_W'(-sht) : DV_W'(sht);
      dmag4[1] <= nb3[WW-1] ? DV_W'(-shb) : DV_W'(shb);
      neg4     <= {nb3[WW-1], nt3[WW-1]};
      topf4    <= topf3;
      botf4    <= botf3;
      side_c4  <= side_c3;
    end
  end

  // c5: quotient overflow check, divider set-up
  logic                 vc5;
  logic [1:0]           sat_c;
  logic [1:0][Q_W-1:0]  dvd5;
  logic [1:0][AT_W-1:0] rin5;
  logic [AT_W-1:0]      at5;
  div_side_t            dside5;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sat_c[l] = (dmag4[l][DV_W-1:Q_W] >= TOP_W'(side_c4.at));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        dvd5[l] <= dmag4[l][Q_W-1:0];
        rin5[l] <= sat_c[l] ? '0 : dmag4[l][AT_W+Q_W-1:Q_W];
      end
      at5         <= side_c4.at;
      dside5.topf <= topf4 & !side_c4.bz;
      dside5.botf <= botf4 & !side_c4.bz;
      dside5.lo   <= side_c4.lo;
      dside5.hi   <= side_c4.hi;
      dside5.neg  <= neg4;
      dside5.sat  <= sat_c;
    end
  end

  logic                dv_v;
  logic [1:0][Q_W-1:0] dv_q;
  logic [1:0]          dv_rnz;
  div_side_t           dv_side;

  bayb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vc5),
    .dividend  (dvd5),
    .rem_init  (rin5),
    .divisor   (at5),
    .in_side   (dside5),
    .out_valid (dv_v),
    .quot      (dv_q),
    .rem_nz    (dv_rnz),
    .out_side  (dv_side)
  );

  // floor of a signed quotient, saturated to the coordinate range
  function automatic logic signed [COORD_W-1:0] arc_value(input logic [Q_W-1:0] q,
                                                          input logic rnz,
                                                          input logic neg,
                                                          input logic sat);
    logic [Q_W:0]             m;
    logic signed [Q_W+1:0]    v;
    logic signed [COORD_W-1:0] r;
    m = (Q_W+1)'(q) + (Q_W+1)'(neg & rnz);
    v = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    if (sat) begin
      r = neg ? COORD_MIN : COORD_MAX;
    end else if (v > (Q_W+2)'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < (Q_W+2)'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = COORD_W'(v);
    end
    return r;
  endfunction

  // f1: arc extremes
  logic                      vf;
  logic signed [COORD_W-1:0] arc_t, arc_b;
  div_side_t                 side_f;

  always_ff @(posedge clk) begin
    if (en) begin
      arc_t  <= arc_value(dv_q[0], dv_rnz[0], dv_side.neg[0], dv_side.sat[0]);
      arc_b  <= arc_value(dv_q[1], dv_rnz[1], dv_side.neg[1], dv_side.sat[1]);
      side_f <= dv_side;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;  v2 <= 1'b0;  v3 <= 1'b0;  v4 <= 1'b0;
      vm0 <= 1'b0; vm1 <= 1'b0; vm2 <= 1'b0; vm3 <= 1'b0;
      vc1 <= 1'b0; vc2 <= 1'b0; vc3 <= 1'b0; vc4 <= 1'b0; vc5 <= 1'b0;
      vf <= 1'b0;
    end else if (en) begin
      v1 <= seg_valid;  v2 <= v1;   v3 <= v2;   v4 <= v3;
      vm0 <= sq_v; vm1 <= vm0; vm2 <= vm1; vm3 <= vm2;
      vc1 <= vm3;  vc2 <= vc1; vc3 <= vc2; vc4 <= vc3; vc5 <= vc4;
      vf <= dv_v;
    end
  end

  // pipeline tail: an extreme only widens the endpoint bounds
  bnd_t p_data;

  always_comb begin
    p_data.low_y          = (side_f.botf && (arc_b < side_f.lo)) ? arc_b : side_f.lo;
    p_data.high_y         = (side_f.topf && (arc_t > side_f.hi)) ? arc_t : side_f.hi;
    p_data.top_reached    = side_f.topf;
    p_data.bottom_reached = side_f.botf;
  end

  // output register with skid register behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      bnd_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!bnd_valid || !bnd_stall) begin
      if (skid_v) begin
        bnd_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        bnd_valid <= vf;
      end
    end else if (vf && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!bnd_valid || !bnd_stall) begin
      bnd <= skid_v ? skid_d : p_data;
    end else if (vf && en) begin
      skid_d <= p_data;
    end
  end

  // skid register only fills behind a held result
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(bnd_valid && bnd_stall))
    else $error("skid register filled while output was free");

  a_skid_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> bnd_valid)
    else $error("skid register full with empty output register");

  a_order: assert property (@(posedge clk) disable iff (rst)
    bnd_valid |-> (bnd.low_y <= bnd.high_y))
    else $error("low bound above high bound");

endmodule
`default_nettype wire
